>>> hdl/fire_effect_heat_update_macros.svh
// Assertion shorthands shared by the heat update RTL.
`ifndef FIRE_EFFECT_HEAT_UPDATE_MACROS_SVH
`define FIRE_EFFECT_HEAT_UPDATE_MACROS_SVH

// Condition that holds at every clock edge out of reset.
`define FEHU_CHECK(lbl, expr, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (expr)) else $error(msg);

// Same-cycle implication.
`define FEHU_IMPLIES(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

`endif

>>> hdl/fehu_pkg.sv
package fehu_pkg;

    // Field widths
    localparam int IDX_W     = 15;
    localparam int OFS_W     = 2;
    localparam int HEAT_W    = 6;
    localparam int COLOR_W   = 16;
    localparam int S_TDATA_W = 24;
    localparam int M_TDATA_W = 24;

    localparam logic [HEAT_W-1:0] HEAT_MAX = 6'd35;

    // Output queue sizing
    localparam int OUTQ_DEPTH = 4;
    localparam int OUTQ_PTR_W = 2;
    localparam int OUTQ_CNT_W = 3;

    typedef enum logic
    {
        MODE_SPREAD = 1'b0,
        MODE_READ   = 1'b1
    } mode_t;

    typedef enum logic
    {
        ST_CLEAR = 1'b0,
        ST_RUN   = 1'b1
    } state_t;

    typedef struct packed
    {
        logic                dropped;
        logic [COLOR_W-1:0]  color;
        logic [HEAT_W-1:0]   heat;
    } res_t;

    // Flame palette, RGB565 with bytes swapped; heat above the top saturates
    function automatic logic [COLOR_W-1:0] palette_color(input logic [HEAT_W-1:0] heat);
        logic [COLOR_W-1:0] c;
        case (heat)
            6'd0:    c = 16'h2000;
            6'd1:    c = 16'h2018;
            6'd2:    c = 16'h6028;
            6'd3:    c = 16'h6040;
            6'd4:    c = 16'ha050;
            6'd5:    c = 16'he060;
            6'd6:    c = 16'he070;
            6'd7:    c = 16'h2089;
            6'd8:    c = 16'h6099;
            6'd9:    c = 16'he0a9;
            6'd10:   c = 16'h20ba;
            6'd11:   c = 16'h20c2;
            6'd12:   c = 16'h60da;
            6'd13:   c = 16'ha0da;
            6'd14:   c = 16'ha0da;
            6'd15:   c = 16'he0d2;
            6'd16:   c = 16'h21d3;
            6'd17:   c = 16'h61cb;
            6'd18:   c = 16'ha1cb;
            6'd19:   c = 16'he1cb;
            6'd20:   c = 16'h22cc;
            6'd21:   c = 16'h22c4;
            6'd22:   c = 16'h62c4;
            6'd23:   c = 16'ha3c4;
            6'd24:   c = 16'he3bc;
            6'd25:   c = 16'he3bc;
            6'd26:   c = 16'h24bd;
            6'd27:   c = 16'h24bd;
            6'd28:   c = 16'h65bd;
            6'd29:   c = 16'h65b5;
            6'd30:   c = 16'ha5b5;
            6'd31:   c = 16'ha6b5;
            6'd32:   c = 16'h6dce;
            6'd33:   c = 16'hf3de;
            6'd34:   c = 16'h78ef;
            default: c = 16'hffff;
        endcase
        return c;
    endfunction

endpackage

>>> hdl/fehu_ram.sv
// Simple dual-port RAM, one write port, one registered read port (old data on collision)
module fehu_ram #(
    parameter int WIDTH = 6,
    parameter int DEPTH = 25600
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

>>> hdl/fehu_outq.sv
// Small result queue between the update stage and the output port
module fehu_outq (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            push,
    input  fehu_pkg::res_t                  push_data,
    input  logic                            pop,
    output logic                            valid,
    output fehu_pkg::res_t                  data,
    output logic [fehu_pkg::OUTQ_CNT_W-1:0] count
);

    fehu_pkg::res_t                  entry_reg [fehu_pkg::OUTQ_DEPTH];
    logic [fehu_pkg::OUTQ_PTR_W-1:0] wr_ptr_reg;
    logic [fehu_pkg::OUTQ_PTR_W-1:0] rd_ptr_reg;
    logic [fehu_pkg::OUTQ_CNT_W-1:0] count_reg;
    logic [fehu_pkg::OUTQ_CNT_W-1:0] count_next;
    logic                            do_pop;

    assign valid  = (count_reg != '0);
    assign do_pop = pop && valid;
    assign data   = entry_reg[rd_ptr_reg];
    assign count  = count_reg;

    // Occupancy
    always_comb
    begin
        count_next = count_reg;
        if (push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (!push && do_pop)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    // Pointers and occupancy register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (do_pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            count_reg <= count_next;
        end
    end

    // Storage
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

>>> hdl/fire_effect_heat_update.sv
// An accepted item is registered in the update stage, then pushed into the output queue that drives m_axis.
// Throughput: one item per cycle while the output queue has room; heat RAM is read at accept and written
// back from the update stage, with a one-deep forward covering a read of the entry written in the same cycle.
// Reset: rst_n clears control at once, then a clearing pass over all FIRE_COLUMNS*FIRE_ROWS entries
// (25600 by default) loads row 0 with heat 35 and the rest with 0; s_axis_tready is low meanwhile.
`include "fire_effect_heat_update_macros.svh"

module fire_effect_heat_update #(
    parameter int FIRE_COLUMNS = 320,
    parameter int FIRE_ROWS    = 80
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             s_axis_tvalid,
    output logic                             s_axis_tready,
    // [14:0] pixel_index, [16:15] random_offset, rest zero
    input  logic [fehu_pkg::S_TDATA_W-1:0]   s_axis_tdata,
    // [0] mode
    input  logic                             s_axis_tuser,
    output logic                             m_axis_tvalid,
    input  logic                             m_axis_tready,
    // [5:0] heat_level, [21:6] pixel_color, [22] write_dropped, rest zero
    output logic [fehu_pkg::M_TDATA_W-1:0]   m_axis_tdata
);

    localparam int PIXELS = FIRE_COLUMNS * FIRE_ROWS;
    localparam int ADDR_W = $clog2(PIXELS);
    localparam int CALC_W = ((ADDR_W > fehu_pkg::IDX_W) ? ADDR_W : fehu_pkg::IDX_W) + 2;
    localparam int HW     = fehu_pkg::HEAT_W;

    localparam logic signed [CALC_W-1:0] COLS_C = CALC_W'(FIRE_COLUMNS);
    localparam logic signed [CALC_W-1:0] PIX_C  = CALC_W'(PIXELS);
    localparam logic [ADDR_W-1:0]        LAST_A = ADDR_W'(PIXELS - 1);
    localparam logic [ADDR_W-1:0]        COLS_A = ADDR_W'(FIRE_COLUMNS);

    localparam logic [fehu_pkg::OUTQ_CNT_W-1:0] Q_DEPTH_C =
        fehu_pkg::OUTQ_CNT_W'(fehu_pkg::OUTQ_DEPTH);

    // Clearing sequencer
    fehu_pkg::state_t     state_reg;
    fehu_pkg::state_t     state_next;
    logic [ADDR_W-1:0]    clr_addr_reg;
    logic                 clr_active;

    // Input decode
    logic                       accept;
    fehu_pkg::mode_t            in_mode;
    logic [fehu_pkg::IDX_W-1:0] in_idx;
    logic [fehu_pkg::OFS_W-1:0] in_ofs;
    logic signed [CALC_W-1:0]   idx_s;
    logic signed [CALC_W-1:0]   ofs_s;
    logic signed [CALC_W-1:0]   src_s;
    logic signed [CALC_W-1:0]   tgt_s;
    logic                       src_ok;
    logic                       rd_ok;
    logic                       tgt_ok;
    logic [ADDR_W-1:0]          rd_addr;

    // Update stage
    logic                 s1_valid_reg;
    fehu_pkg::mode_t      s1_mode_reg;
    logic                 s1_dec_reg;
    logic                 s1_rd_ok_reg;
    logic                 s1_tgt_ok_reg;
    logic [ADDR_W-1:0]    s1_tgt_addr_reg;
    logic                 fwd_hit_reg;
    logic [HW-1:0]        fwd_data_reg;
    logic [HW-1:0]        ram_rd_data;
    logic [HW-1:0]        s1_src;
    logic [HW-1:0]        s1_heat;
    logic                 s1_wr_en;
    logic                 s1_dropped;
    fehu_pkg::res_t       s1_res;

    // RAM write port
    logic                 ram_wr_en;
    logic [ADDR_W-1:0]    ram_wr_addr;
    logic [HW-1:0]        ram_wr_data;

    // Output queue
    fehu_pkg::res_t                  q_data;
    logic                            q_valid;
    logic [fehu_pkg::OUTQ_CNT_W-1:0] q_count;

    // Next state of the clearing sequencer
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            fehu_pkg::ST_CLEAR:
            begin
                if (clr_addr_reg == LAST_A)
                begin
                    state_next = fehu_pkg::ST_RUN;
                end
            end
            fehu_pkg::ST_RUN:
            begin
                state_next = fehu_pkg::ST_RUN;
            end
            default:
            begin
                state_next = fehu_pkg::ST_CLEAR;
            end
        endcase
    end

    // Sequencer outputs
    always_comb
    begin
        unique case (state_reg)
            fehu_pkg::ST_CLEAR: clr_active = 1'b1;
            fehu_pkg::ST_RUN:   clr_active = 1'b0;
            default:            clr_active = 1'b1;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= fehu_pkg::ST_CLEAR;
            clr_addr_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (clr_active)
            begin
                clr_addr_reg <= clr_addr_reg + 1'b1;
            end
        end
    end

    // Room for every item in flight plus the new one
    assign s_axis_tready = !clr_active
        && ((q_count + fehu_pkg::OUTQ_CNT_W'(s1_valid_reg)) < Q_DEPTH_C);
    assign accept = s_axis_tvalid && s_axis_tready;

    // Address arithmetic for the accepted item
    assign in_mode = fehu_pkg::mode_t'(s_axis_tuser);
    assign in_idx  = s_axis_tdata[fehu_pkg::IDX_W-1:0];
    assign in_ofs  = s_axis_tdata[fehu_pkg::IDX_W +: fehu_pkg::OFS_W];
    assign idx_s   = $signed({{(CALC_W - fehu_pkg::IDX_W){1'b0}}, in_idx});
    assign ofs_s   = $signed({{(CALC_W - fehu_pkg::OFS_W){in_ofs[fehu_pkg::OFS_W-1]}}, in_ofs});
    assign src_s   = idx_s - COLS_C;
    assign tgt_s   = idx_s - ofs_s;
    assign src_ok  = (src_s >= 0) && (src_s < PIX_C);
    assign tgt_ok  = (tgt_s >= 0) && (tgt_s < PIX_C);

    always_comb
    begin
        if (in_mode == fehu_pkg::MODE_READ)
        begin
            rd_addr = idx_s[ADDR_W-1:0];
            rd_ok   = (idx_s < PIX_C);
        end
        else
        begin
            rd_addr = src_s[ADDR_W-1:0];
            rd_ok   = src_ok;
        end
    end

    // Stage control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            fwd_hit_reg  <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= accept;
            fwd_hit_reg  <= accept && s1_wr_en && rd_ok && (s1_tgt_addr_reg == rd_addr);
        end
    end

    // Stage payload
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_mode_reg     <= in_mode;
            s1_dec_reg      <= in_ofs[0];
            s1_rd_ok_reg    <= rd_ok;
            s1_tgt_ok_reg   <= (in_mode == fehu_pkg::MODE_SPREAD) && tgt_ok;
            s1_tgt_addr_reg <= tgt_s[ADDR_W-1:0];
            fwd_data_reg    <= s1_heat;
        end
    end

    // Source heat: forwarded write, RAM, or zero off the buffer
    always_comb
    begin
        if (!s1_rd_ok_reg)
        begin
            s1_src = '0;
        end
        else if (fwd_hit_reg)
        begin
            s1_src = fwd_data_reg;
        end
        else
        begin
            s1_src = ram_rd_data;
        end
    end

    // Heat decay and write-back
    always_comb
    begin
        if (s1_mode_reg == fehu_pkg::MODE_READ)
        begin
            s1_heat = s1_src;
        end
        else if (s1_src != '0)
        begin
            s1_heat = s1_src - {{(HW - 1){1'b0}}, s1_dec_reg};
        end
        else
        begin
            s1_heat = '0;
        end
    end

    assign s1_wr_en   = s1_valid_reg && s1_tgt_ok_reg;
    assign s1_dropped = (s1_mode_reg == fehu_pkg::MODE_SPREAD) && !s1_tgt_ok_reg;

    assign s1_res.heat    = s1_heat;
    assign s1_res.color   = fehu_pkg::palette_color(s1_heat);
    assign s1_res.dropped = s1_dropped;

    // Write port: clearing pass or item write-back
    always_comb
    begin
        if (clr_active)
        begin
            ram_wr_en   = 1'b1;
            ram_wr_addr = clr_addr_reg;
            ram_wr_data = (clr_addr_reg < COLS_A) ? fehu_pkg::HEAT_MAX : '0;
        end
        else
        begin
            ram_wr_en   = s1_wr_en;
            ram_wr_addr = s1_tgt_addr_reg;
            ram_wr_data = s1_heat;
        end
    end

    fehu_ram #(
        .WIDTH (HW),
        .DEPTH (PIXELS)
    ) u_heat_ram (
        .clk     (clk),
        .wr_en   (ram_wr_en),
        .wr_addr (ram_wr_addr),
        .wr_data (ram_wr_data),
        .rd_en   (accept),
        .rd_addr (rd_addr),
        .rd_data (ram_rd_data)
    );

    fehu_outq u_outq (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (s1_valid_reg),
        .push_data (s1_res),
        .pop       (m_axis_tready),
        .valid     (q_valid),
        .data      (q_data),
        .count     (q_count)
    );

    assign m_axis_tvalid = q_valid;
    assign m_axis_tdata  = {{(fehu_pkg::M_TDATA_W - $bits(fehu_pkg::res_t)){1'b0}}, q_data};

    // Checks
    `FEHU_IMPLIES(a_no_item_in_clear, s1_valid_reg, !clr_active, "item during clearing pass")
    `FEHU_CHECK(a_queue_room, (q_count + fehu_pkg::OUTQ_CNT_W'(s1_valid_reg)) <= Q_DEPTH_C, "queue overrun")
    `FEHU_IMPLIES(a_heat_range, s1_valid_reg, s1_heat <= fehu_pkg::HEAT_MAX, "heat above range")
    `FEHU_IMPLIES(a_fwd_source, fwd_hit_reg, s1_valid_reg && $past(s1_wr_en), "stray forward")

endmodule
